[hw/rtl/esc_pkg.sv]
// Shared types, constants and the month length table for the epoch seconds converter.
package esc_pkg;

    localparam int UNIT_W = 32;
    typedef logic [UNIT_W-1:0] unit_t;

    localparam logic [31:0] EPOCH_2000_OFFSET = 32'd946684800;
    localparam logic [11:0] BASE_YEAR         = 12'd2000;
    localparam logic [6:0]  YEAR_2100_OFFSET  = 7'd100;
    localparam logic [3:0]  LAST_MONTH_INDEX  = 4'd11;
    localparam logic [2:0]  DOW_SATURDAY      = 3'd6;

    localparam logic [6:0]  DIV_SIXTY  = 7'd60;
    localparam logic [6:0]  DIV_HOURS  = 7'd24;
    localparam logic [6:0]  DIV_WEEK   = 7'd7;

    // Reciprocals rounded up. The quotient is the product shifted right by 37, 36 and 32
    // bits respectively, and each is exact over the whole 32-bit operand range it sees.
    localparam logic [31:0] RECIP_SIXTY = 32'h8888_8889;
    localparam logic [31:0] RECIP_HOURS = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP_WEEK  = 32'h2492_4925;

    localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;
    localparam logic [8:0]  DAYS_LEAP_YEAR   = 9'd366;

    localparam int DATA_W = 48;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_SUB    = 14'b00000000000010,
        ST_MUL_S  = 14'b00000000000100,
        ST_QUO_S  = 14'b00000000001000,
        ST_REM_S  = 14'b00000000010000,
        ST_QUO_M  = 14'b00000000100000,
        ST_REM_M  = 14'b00000001000000,
        ST_QUO_H  = 14'b00000010000000,
        ST_REM_H  = 14'b00000100000000,
        ST_QUO_W  = 14'b00001000000000,
        ST_REM_W  = 14'b00010000000000,
        ST_YEAR   = 14'b00100000000000,
        ST_MONTH  = 14'b01000000000000,
        ST_FINISH = 14'b10000000000000
    } state_t;

    // Month index runs from 0 for January to 11 for December.
    function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        case (idx)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[hw/rtl/esc_cmp_sub.sv]
// Shared compare and subtract unit used by the offset, remainder, year and month steps of the conversion.
module esc_cmp_sub (
    input  esc_pkg::unit_t a,
    input  esc_pkg::unit_t b,
    output logic           ge,
    output esc_pkg::unit_t diff
);
    import esc_pkg::*;

    logic [UNIT_W:0] wide_diff;

    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign ge        = ~wide_diff[UNIT_W];
    assign diff      = wide_diff[UNIT_W-1:0];

endmodule

[hw/rtl/epoch_seconds_to_calendar.sv]
// Top level of the Unix seconds to calendar date converter.
//
// An item on the slave stream carries a 32-bit Unix time in seconds. Each item
// gives exactly one item on the master stream with year, month, day, hour,
// minute, second and weekday, plus an error flag in tuser for times before the
// year 2000, in which case every data field is zero.
// Subtraction and comparison run on one shared 32-bit compare and subtract unit,
// beside one 32 by 32 multiplier. Each division by 60, 60, 24 and 7 takes a
// reciprocal multiplication for the quotient, a multiplication back by the
// divisor, and the remainder on the shared unit. The offset is removed first,
// then the divisions run, whole years are removed one at a time, then whole
// months one at a time, and last the output register is loaded. A time before
// 2000 goes from the offset step straight to loading the output register. The
// block accepts a new item only while idle.
// A finished result waits in the output register while the receiver stalls;
// the block can take the next item meanwhile and holds its own result back
// until the register is free. Reset empties the block and the output register.
module epoch_seconds_to_calendar (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // unix_seconds[31:0]
    input  logic [31:0]                 s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // calendar_year[11:0], month_number[15:12], day_of_month[20:16],
    // hour_of_day[25:21], minute_of_hour[31:26], second_of_minute[37:32],
    // day_of_week[40:38], zero fill[47:41]
    output logic [esc_pkg::DATA_W-1:0]  m_tdata,
    // before_epoch_error[0]
    output logic                        m_tuser
);
    import esc_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] num_reg,   num_next;
    logic [31:0] quo_reg,   quo_next;
    logic [63:0] prod_reg,  prod_next;
    logic [5:0]  sec_reg,   sec_next;
    logic [5:0]  min_reg,   min_next;
    logic [4:0]  hour_reg,  hour_next;
    logic [2:0]  dow_reg,   dow_next;
    logic [15:0] days_reg,  days_next;
    logic [6:0]  yoff_reg,  yoff_next;
    logic [3:0]  mon_reg,   mon_next;
    logic        err_reg,   err_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    out_data_reg,  out_data_next;
    logic                 out_err_reg,   out_err_next;

    unit_t       unit_a, unit_b, unit_diff;
    logic        unit_ge;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;
    logic [31:0] quo_now;
    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mon_len;

    esc_cmp_sub u_unit (
        .a    (unit_a),
        .b    (unit_b),
        .ge   (unit_ge),
        .diff (unit_diff)
    );

    assign leap     = (yoff_reg[1:0] == 2'd0) && (yoff_reg != YEAR_2100_OFFSET);
    assign year_len = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
    assign mon_len  = month_days(mon_reg, leap);
    assign mul_prod = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb
    begin
        case (state_reg)
            ST_QUO_H: quo_now = {4'd0, prod_reg[63:36]};
            ST_QUO_W: quo_now = prod_reg[63:32];
            default:  quo_now = {5'd0, prod_reg[63:37]};
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_MUL_S:
            begin
                mul_a = num_reg;
                mul_b = RECIP_SIXTY;
            end
            ST_QUO_S, ST_QUO_M:
            begin
                mul_a = quo_now;
                mul_b = {{(UNIT_W-7){1'b0}}, DIV_SIXTY};
            end
            ST_QUO_H:
            begin
                mul_a = quo_now;
                mul_b = {{(UNIT_W-7){1'b0}}, DIV_HOURS};
            end
            ST_QUO_W:
            begin
                mul_a = quo_now;
                mul_b = {{(UNIT_W-7){1'b0}}, DIV_WEEK};
            end
            ST_REM_S:
            begin
                mul_a = quo_reg;
                mul_b = RECIP_SIXTY;
            end
            ST_REM_M:
            begin
                mul_a = quo_reg;
                mul_b = RECIP_HOURS;
            end
            ST_REM_H:
            begin
                mul_a = quo_reg;
                mul_b = RECIP_WEEK;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_SUB:
            begin
                unit_a = num_reg;
                unit_b = EPOCH_2000_OFFSET;
            end
            ST_REM_S, ST_REM_M, ST_REM_H, ST_REM_W:
            begin
                unit_a = num_reg;
                unit_b = prod_reg[31:0];
            end
            ST_YEAR:
            begin
                unit_a = {{(UNIT_W-16){1'b0}}, days_reg};
                unit_b = {{(UNIT_W-9){1'b0}}, year_len};
            end
            ST_MONTH:
            begin
                unit_a = {{(UNIT_W-16){1'b0}}, days_reg};
                unit_b = {{(UNIT_W-5){1'b0}}, mon_len};
            end
            default:
            begin
                unit_a = '0;
                unit_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        prod_next      = prod_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        dow_next       = dow_reg;
        days_next      = days_reg;
        yoff_next      = yoff_reg;
        mon_next       = mon_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    num_next   = s_tdata;
                    err_next   = 1'b0;
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                if (unit_ge)
                begin
                    num_next   = unit_diff;
                    state_next = ST_MUL_S;
                end
                else
                begin
                    err_next   = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_S:
            begin
                prod_next  = mul_prod;
                state_next = ST_QUO_S;
            end
            ST_QUO_S:
            begin
                quo_next   = quo_now;
                prod_next  = mul_prod;
                state_next = ST_REM_S;
            end
            ST_REM_S:
            begin
                sec_next   = unit_diff[5:0];
                num_next   = quo_reg;
                prod_next  = mul_prod;
                state_next = ST_QUO_M;
            end
            ST_QUO_M:
            begin
                quo_next   = quo_now;
                prod_next  = mul_prod;
                state_next = ST_REM_M;
            end
            ST_REM_M:
            begin
                min_next   = unit_diff[5:0];
                num_next   = quo_reg;
                prod_next  = mul_prod;
                state_next = ST_QUO_H;
            end
            ST_QUO_H:
            begin
                quo_next   = quo_now;
                prod_next  = mul_prod;
                state_next = ST_REM_H;
            end
            ST_REM_H:
            begin
                hour_next  = unit_diff[4:0];
                days_next  = quo_reg[15:0];
                num_next   = quo_reg;
                prod_next  = mul_prod;
                state_next = ST_QUO_W;
            end
            ST_QUO_W:
            begin
                quo_next   = quo_now;
                prod_next  = mul_prod;
                state_next = ST_REM_W;
            end
            ST_REM_W:
            begin
                // The first day of 2000 was a Saturday, so a whole number of weeks lands there.
                if (unit_diff[2:0] == 3'd0)
                begin
                    dow_next = DOW_SATURDAY;
                end
                else
                begin
                    dow_next = unit_diff[2:0] - 3'd1;
                end
                yoff_next  = '0;
                state_next = ST_YEAR;
            end
            ST_YEAR:
            begin
                if (unit_ge)
                begin
                    days_next = unit_diff[15:0];
                    yoff_next = yoff_reg + 7'd1;
                end
                else
                begin
                    mon_next   = '0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (unit_ge && (mon_reg != LAST_MONTH_INDEX))
                begin
                    days_next = unit_diff[15:0];
                    mon_next  = mon_reg + 4'd1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_err_next   = err_reg;
                    if (err_reg)
                    begin
                        out_data_next = '0;
                    end
                    else
                    begin
                        out_data_next = {7'd0, dow_reg, sec_reg, min_reg, hour_reg,
                                         days_reg[4:0] + 5'd1, mon_reg + 4'd1,
                                         BASE_YEAR + {5'd0, yoff_reg}};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        quo_reg      <= quo_next;
        prod_reg     <= prod_next;
        sec_reg      <= sec_next;
        min_reg      <= min_next;
        hour_reg     <= hour_next;
        dow_reg      <= dow_next;
        days_reg     <= days_next;
        yoff_reg     <= yoff_next;
        mon_reg      <= mon_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    // An accepted item keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // An error result carries all data fields as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("error result with non-zero fields");

    // A valid date has month 1 to 12 and a non-zero day.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |->
            ((m_tdata[15:12] != 4'd0) && (m_tdata[15:12] <= 4'd12)
             && (m_tdata[20:16] != 5'd0)))
        else $error("date out of range");

    // The output register is only loaded once the receiver has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result overwritten");

endmodule
